// ===== design/ptbb_pkg.sv =====
// Package for the point transform and bounding box block.
// Widths, register indexes, row codes, rotation constants and the control types.
// Stands alone; every design file imports it.
package ptbb_pkg;

	localparam int COEF_FRAC_BITS = 14;
	localparam int COORD_W        = 32;
	localparam int COEF_W         = 16;
	localparam int PROD_W         = COORD_W + COEF_W;
	localparam int ACC_W          = PROD_W + 3;
	localparam int CFG_W          = 48;
	localparam int CFG_IDX_W      = 3;
	localparam int ROW_W          = 3;
	localparam int TERM_W         = 2;
	localparam int IN_DATA_W      = 120;
	localparam int OUT_DATA_W     = 312;

	// cos and sin of 5 degrees in 2^30 units, rounded to the coefficient format
	localparam longint COS5_Q30 = 64'sd1069655912;
	localparam longint SIN5_Q30 = 64'sd93582766;
	localparam int     TRIG_SH  = 30 - COEF_FRAC_BITS;
	localparam logic signed [COEF_W-1:0] COEF_C5 =
		COEF_W'((COS5_Q30 + (64'sd1 <<< (TRIG_SH - 1))) >>> TRIG_SH);
	localparam logic signed [COEF_W-1:0] COEF_S5 =
		COEF_W'((SIN5_Q30 + (64'sd1 <<< (TRIG_SH - 1))) >>> TRIG_SH);

	localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] NEG_MAX = 32'sh8000_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_COS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_SIN = 3'd7;

	// one row is one rounded sum of products
	localparam logic [ROW_W-1:0] ROW_PX = 3'd0;
	localparam logic [ROW_W-1:0] ROW_PY = 3'd1;
	localparam logic [ROW_W-1:0] ROW_PZ = 3'd2;
	localparam logic [ROW_W-1:0] ROW_RX = 3'd3;
	localparam logic [ROW_W-1:0] ROW_RZ = 3'd4;
	localparam logic [ROW_W-1:0] ROW_OX = 3'd5;
	localparam logic [ROW_W-1:0] ROW_OY = 3'd6;

	localparam logic [TERM_W-1:0] TERM_0 = 2'd0;
	localparam logic [TERM_W-1:0] TERM_1 = 2'd1;
	localparam logic [TERM_W-1:0] TERM_2 = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              load_in;
		logic              issue;
		logic              init;
		logic              fin;
		logic              emit;
		logic [ROW_W-1:0]  row;
		logic [TERM_W-1:0] term;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage

// ===== design/ptbb_ctrl.sv =====
// Sequencer of the point transform: walks rows and product terms
// through the shared multiply-accumulate datapath. Uses ptbb_pkg.
module ptbb_ctrl import ptbb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  row_q;
	logic [TERM_W-1:0] term_q;
	logic [TERM_W-1:0] last_term;
	logic              accept;

	// matrix rows have three products, the rotations two
	assign last_term = (row_q <= ROW_PZ) ? TERM_2 : TERM_1;
	assign accept    = s_tvalid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_MAC;
			ST_MAC:   if (term_q == last_term) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   state_d = (row_q == ROW_OY) ? ST_EMIT : ST_MAC;
			ST_EMIT:  if (!status.out_busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.load_in = 1'b0;
		cmd.issue   = 1'b0;
		cmd.init    = 1'b0;
		cmd.fin     = 1'b0;
		cmd.emit    = 1'b0;
		cmd.row     = row_q;
		cmd.term    = term_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				cmd.init  = (term_q == TERM_0);
			end
			ST_DRAIN: ;
			ST_FIN:  cmd.fin  = 1'b1;
			ST_EMIT: cmd.emit = !status.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= ROW_PX;
			term_q  <= TERM_0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				row_q  <= ROW_PX;
				term_q <= TERM_0;
			end else if (state_q == ST_MAC) begin
				if (term_q != last_term) term_q <= term_q + TERM_W'(1);
			end else if (state_q == ST_DRAIN) begin
				term_q <= TERM_0;
			end else if (state_q == ST_FIN && row_q != ROW_OY) begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

endmodule

// ===== design/ptbb_datapath.sv =====
// Datapath of the point transform: configuration registers, one 16x32
// multiplier, accumulator, saturation, working registers, box and output word.
// Uses ptbb_pkg; driven by ptbb_ctrl.
module ptbb_datapath import ptbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam logic signed [ACC_W-1:0] ACC_HALF    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] ACC_POS_MAX = ACC_W'(POS_MAX);
	localparam logic signed [ACC_W-1:0] ACC_NEG_MAX = ACC_W'(NEG_MAX);

	logic [CFG_W-1:0]          mline_q [3];
	logic signed [COORD_W-1:0] off_q   [3];
	logic signed [COEF_W-1:0]  hcos_q, hsin_q;

	logic signed [COORD_W-1:0] v_q [3];
	logic [23:0]               rgb_q;

	logic signed [COORD_W-1:0] wx_q, wy_q, wz_q, rx_q, rz_q, ox_q, oy_q;

	logic signed [COEF_W-1:0]  op_a;
	logic signed [COORD_W-1:0] op_b;
	logic                      op_sub;
	logic signed [ACC_W-1:0]   init_val;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      acc_en_s1, sub_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_shr;
	logic signed [COORD_W-1:0] sum_sat, sum_neg;

	logic signed [COORD_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;
	logic signed [COORD_W-1:0] lo_x_d, hi_x_d, lo_y_d, hi_y_d, lo_z_d, hi_z_d;
	logic                      out_valid_q;
	logic [OUT_DATA_W-1:0]     out_word_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mline_q[0] <= 48'h0000_0000_4000;
			mline_q[1] <= 48'h0000_4000_0000;
			mline_q[2] <= 48'h4000_0000_0000;
			off_q[0]   <= '0;
			off_q[1]   <= '0;
			off_q[2]   <= '0;
			hcos_q     <= 16'sd16384;
			hsin_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATRIX0:     mline_q[0] <= cfg_data;
				REG_MATRIX1:     mline_q[1] <= cfg_data;
				REG_MATRIX2:     mline_q[2] <= cfg_data;
				REG_OFFSET_X:    off_q[0]   <= cfg_data[COORD_W-1:0];
				REG_OFFSET_Y:    off_q[1]   <= cfg_data[COORD_W-1:0];
				REG_OFFSET_Z:    off_q[2]   <= cfg_data[COORD_W-1:0];
				REG_HEADING_COS: hcos_q     <= cfg_data[COEF_W-1:0];
				REG_HEADING_SIN: hsin_q     <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// input word: coord_x, coord_y, coord_z, red, green, blue
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q[0] <= s_tdata[31:0];
			v_q[1] <= s_tdata[63:32];
			v_q[2] <= s_tdata[95:64];
			rgb_q  <= s_tdata[119:96];
		end
	end

	// operand selection per row and term
	always_comb begin
		op_a     = hcos_q;
		op_b     = wx_q;
		op_sub   = 1'b0;
		init_val = ACC_HALF;
		case (cmd.row) inside
			ROW_PX, ROW_PY, ROW_PZ: begin
				op_a     = mline_q[cmd.row[1:0]][COEF_W*cmd.term +: COEF_W];
				op_b     = v_q[cmd.term];
				// offset preloaded above the rounding point
				init_val = (ACC_W'(off_q[cmd.row[1:0]]) <<< COEF_FRAC_BITS) + ACC_HALF;
			end
			ROW_RX: begin
				op_a = (cmd.term == TERM_0) ? hcos_q : hsin_q;
				op_b = (cmd.term == TERM_0) ? wx_q : wz_q;
			end
			ROW_RZ: begin
				op_a   = (cmd.term == TERM_0) ? hcos_q : hsin_q;
				op_b   = (cmd.term == TERM_0) ? wz_q : wx_q;
				op_sub = (cmd.term != TERM_0);
			end
			ROW_OX: begin
				op_a   = (cmd.term == TERM_0) ? COEF_C5 : COEF_S5;
				op_b   = (cmd.term == TERM_0) ? rx_q : wy_q;
				op_sub = (cmd.term != TERM_0);
			end
			ROW_OY: begin
				op_a = (cmd.term == TERM_0) ? COEF_S5 : COEF_C5;
				op_b = (cmd.term == TERM_0) ? rx_q : wy_q;
			end
			default: ;
		endcase
	end

	// multiply into a register, then accumulate the registered product in the next cycle
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		sub_s1  <= op_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_en_s1 <= 1'b0;
		else         acc_en_s1 <= cmd.issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.init)
			acc_q <= init_val;
		else if (acc_en_s1)
			acc_q <= sub_s1 ? acc_q - ACC_W'(prod_s1) : acc_q + ACC_W'(prod_s1);
	end

	// floor shift after the half already added, then clamp
	assign acc_shr = acc_q >>> COEF_FRAC_BITS;
	always_comb begin
		if (acc_shr > ACC_POS_MAX)      sum_sat = POS_MAX;
		else if (acc_shr < ACC_NEG_MAX) sum_sat = NEG_MAX;
		else                            sum_sat = acc_shr[COORD_W-1:0];
	end
	assign sum_neg = (sum_sat == NEG_MAX) ? POS_MAX : -sum_sat;

	// fixed x turn folded into the write: qx = px, qy = pz, qz = -py
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			case (cmd.row)
				ROW_PX:  wx_q <= sum_sat;
				ROW_PY:  wz_q <= sum_neg;
				ROW_PZ:  wy_q <= sum_sat;
				ROW_RX:  rx_q <= sum_sat;
				ROW_RZ:  rz_q <= sum_sat;
				ROW_OX:  ox_q <= sum_sat;
				ROW_OY:  oy_q <= sum_sat;
				default: ;
			endcase
		end
	end

	// bounding box, strict compares
	assign lo_x_d = (ox_q < lo_x_q) ? ox_q : lo_x_q;
	assign hi_x_d = (ox_q > hi_x_q) ? ox_q : hi_x_q;
	assign lo_y_d = (oy_q < lo_y_q) ? oy_q : lo_y_q;
	assign hi_y_d = (oy_q > hi_y_q) ? oy_q : hi_y_q;
	assign lo_z_d = (rz_q < lo_z_q) ? rz_q : lo_z_q;
	assign hi_z_d = (rz_q > hi_z_q) ? rz_q : hi_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_x_q      <= POS_MAX;
			hi_x_q      <= NEG_MAX;
			lo_y_q      <= POS_MAX;
			hi_y_q      <= NEG_MAX;
			lo_z_q      <= POS_MAX;
			hi_z_q      <= NEG_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				lo_x_q      <= lo_x_d;
				hi_x_q      <= hi_x_d;
				lo_y_q      <= lo_y_d;
				hi_y_q      <= hi_y_d;
				lo_z_q      <= lo_z_d;
				hi_z_q      <= hi_z_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_word_q <= {hi_z_d, lo_z_d, hi_y_d, lo_y_d, hi_x_d, lo_x_d,
				rgb_q, rz_q, oy_q, ox_q};
	end

	assign status.out_busy = out_valid_q && !m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_word_q;

endmodule

// ===== design/point_transform_bounding_box_top.sv =====
// Top level of the point transform with running bounding box.
// Joins ptbb_ctrl and ptbb_datapath; types and constants from ptbb_pkg.
//
// Each point word is taken through a matrix and offset, a fixed 90 degree turn
// about x, the programmed heading about y and a fixed 5 degree turn about z, every
// stage rounded half up and clamped to signed Q16.16; the result word carries the
// point, its color and the box over all points so far, box reset to empty.
// A new point is accepted only in idle, once the previous one has been written to
// the result register: a single registered 16x32 multiplier forms the 17 products
// of seven rounded sums one at a time, each sum taking its products plus a drain
// and a write step. A result waits in its own register, so a new point is taken
// while the previous result is still held. Configuration writes land at once and
// belong in idle periods only.
module point_transform_bounding_box_top import ptbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// coord_x, coord_y, coord_z, red_in, green_in, blue_in
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pos_x, pos_y, pos_z, red_out, green_out, blue_out,
	// box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z
	output logic [OUT_DATA_W-1:0] m_tdata
);

	cmd_t    cmd;
	status_t status;

	ptbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ptbb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for point_transform_bounding_box_top: directed and random points,
// each result word checked field by field against an in-bench transform and box model.
// Depends on design/ptbb_pkg.sv and the top level RTL.
module tb;
	import ptbb_pkg::*;

	localparam longint TURN5_COS_Q30  = 64'sd1069655912;
	localparam longint TURN5_SIN_Q30  = 64'sd93582766;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     SETTLE_CYCLES  = 40;
	localparam int     MAX_REPORTS    = 60;
	localparam int     NUM_FIELDS     = 12;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// same layout as s_tdata, x in the low bits
	typedef struct packed {
		logic [7:0]         blue, green, red;
		logic signed [31:0] z, y, x;
	} point_t;

	// same layout as m_tdata, pos_x in the low bits
	typedef struct packed {
		logic signed [31:0] max_z, min_z, max_y, min_y, max_x, min_x;
		logic [7:0]         blue, green, red;
		logic signed [31:0] pos_z, pos_y, pos_x;
	} result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	point_t                s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b1;
	logic [OUT_DATA_W-1:0] m_tdata;

	// shadow of the configuration and the running box
	logic [CFG_W-1:0]   coef_line [3];
	logic signed [31:0] offset_q [3];
	logic signed [15:0] head_cos, head_sin;
	logic signed [31:0] box_lo [3];
	logic signed [31:0] box_hi [3];

	result_t pending_results [$];
	int      n_err        = 0;
	int      quiet_cycles = 0;
	int      stall_left   = 0;
	bit      idle_on      = 1'b1;

	point_transform_bounding_box_top DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_coef(longint v);
		return (v + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] clamp_q16(longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return v[31:0];
	endfunction

	function automatic result_t transform_point(point_t pt);
		longint             v [3];
		longint             acc, c, s, c5, s5;
		logic signed [31:0] p [3];
		logic signed [31:0] o [3];
		logic signed [31:0] qx, qy, qz, rx, ry;
		logic signed [15:0] cf;
		result_t            r;
		int                 i, j;
		v[0] = longint'(pt.x);
		v[1] = longint'(pt.y);
		v[2] = longint'(pt.z);
		for (i = 0; i < 3; i++) begin
			acc = 0;
			for (j = 0; j < 3; j++) begin
				cf = coef_line[i][16*j +: 16];
				acc += longint'(cf) * v[j];
			end
			p[i] = clamp_q16(round_coef(acc) + longint'(offset_q[i]));
		end
		// quarter turn about x: (px, pz, -py), negation clamps too
		qx = p[0];
		qy = p[2];
		qz = clamp_q16(-longint'(p[1]));
		c  = longint'(head_cos);
		s  = longint'(head_sin);
		rx = clamp_q16(round_coef(c * longint'(qx) + s * longint'(qz)));
		ry = qy;
		o[2] = clamp_q16(round_coef(c * longint'(qz) - s * longint'(qx)));
		c5 = (TURN5_COS_Q30 + (64'sd1 <<< (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
		s5 = (TURN5_SIN_Q30 + (64'sd1 <<< (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
		o[0] = clamp_q16(round_coef(c5 * longint'(rx) - s5 * longint'(ry)));
		o[1] = clamp_q16(round_coef(s5 * longint'(rx) + c5 * longint'(ry)));
		for (i = 0; i < 3; i++) begin
			if (o[i] > box_hi[i])
				box_hi[i] = o[i];
			if (o[i] < box_lo[i])
				box_lo[i] = o[i];
		end
		r.pos_x = o[0];
		r.pos_y = o[1];
		r.pos_z = o[2];
		r.red   = pt.red;
		r.green = pt.green;
		r.blue  = pt.blue;
		r.min_x = box_lo[0];
		r.max_x = box_hi[0];
		r.min_y = box_lo[1];
		r.max_y = box_hi[1];
		r.min_z = box_lo[2];
		r.max_z = box_hi[2];
		return r;
	endfunction

	function automatic int field_lsb(int k);
		if (k < 3)
			return 32 * k;
		if (k < 6)
			return 96 + 8 * (k - 3);
		return 120 + 32 * (k - 6);
	endfunction

	function automatic string field_name(int k);
		case (k)
			0: return "pos_x";
			1: return "pos_y";
			2: return "pos_z";
			3: return "red_out";
			4: return "green_out";
			5: return "blue_out";
			6: return "box_min_x";
			7: return "box_max_x";
			8: return "box_min_y";
			9: return "box_max_y";
			10: return "box_min_z";
			default: return "box_max_z";
		endcase
	endfunction

	function automatic point_t make_point(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		point_t pt;
		pt.x     = x;
		pt.y     = y;
		pt.z     = z;
		pt.red   = red;
		pt.green = green;
		pt.blue  = blue;
		return pt;
	endfunction

	function automatic logic signed [31:0] random_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 32'(int'($urandom_range(0, 4194304)) - 2097152);
			6, 7, 8: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_line(int diag, bit wild);
		logic [CFG_W-1:0]   line;
		logic signed [15:0] cf;
		int                 j;
		for (j = 0; j < 3; j++) begin
			if (wild)
				cf = 16'($urandom);
			else if (j == diag)
				cf = 16'(16384 + int'($urandom_range(0, 4000)) - 2000);
			else
				cf = 16'(int'($urandom_range(0, 6000)) - 3000);
			line[16*j +: 16] = cf;
		end
		return line;
	endfunction

	task automatic reset_model();
		coef_line[0] = 48'h0000_0000_4000;
		coef_line[1] = 48'h0000_4000_0000;
		coef_line[2] = 48'h4000_0000_0000;
		head_cos     = 16'sd16384;
		head_sin     = 16'sd0;
		for (int i = 0; i < 3; i++) begin
			offset_q[i] = 32'sd0;
			box_lo[i]   = Q_MAX;
			box_hi[i]   = Q_MIN;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MATRIX0:     coef_line[0] = val;
			REG_MATRIX1:     coef_line[1] = val;
			REG_MATRIX2:     coef_line[2] = val;
			REG_OFFSET_X:    offset_q[0] = val[31:0];
			REG_OFFSET_Y:    offset_q[1] = val[31:0];
			REG_OFFSET_Z:    offset_q[2] = val[31:0];
			REG_HEADING_COS: head_cos = val[15:0];
			REG_HEADING_SIN: head_sin = val[15:0];
			default: ;
		endcase
	endtask

	task automatic load_config(logic [CFG_W-1:0] m0, logic [CFG_W-1:0] m1,
		logic [CFG_W-1:0] m2, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [15:0] hc, logic [15:0] hs);
		write_reg(REG_MATRIX0, m0);
		write_reg(REG_MATRIX1, m1);
		write_reg(REG_MATRIX2, m2);
		write_reg(REG_OFFSET_X, {16'h0, ox});
		write_reg(REG_OFFSET_Y, {16'h0, oy});
		write_reg(REG_OFFSET_Z, {16'h0, oz});
		write_reg(REG_HEADING_COS, {32'h0, hc});
		write_reg(REG_HEADING_SIN, {32'h0, hs});
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic settle_idle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_point(point_t pt);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pt;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_results.push_back(transform_point(pt));
		// now and then hold off until the pipe is empty
		if (idle_on && $urandom_range(0, 39) == 0)
			wait_results_done();
	endtask

	task automatic send_random_points(int count);
		repeat (count)
			send_point(make_point(random_coord(), random_coord(), random_coord(),
				8'($urandom), 8'($urandom), 8'($urandom)));
	endtask

	// identity matrix, no offset, zero heading; max z checks the clamped negation
	task automatic test_reset_config();
		send_point(make_point(32'sd0, 32'sd0, 32'sd0, 8'h00, 8'h00, 8'h00));
		send_point(make_point(Q_MAX, Q_MAX, Q_MAX, 8'hff, 8'hff, 8'hff));
		send_point(make_point(Q_MIN, Q_MIN, Q_MIN, 8'h00, 8'hff, 8'h00));
		send_point(make_point(Q_MAX, Q_MIN, 32'sd0, 8'hff, 8'h00, 8'hff));
		send_point(make_point(32'sd0, Q_MIN, Q_MAX, 8'haa, 8'h55, 8'haa));
		send_point(make_point(32'sh0001_0000, -32'sh0002_8000, 32'sh0000_8000,
			8'h55, 8'haa, 8'h55));
		send_point(make_point(-32'sd1, 32'sd1, -32'sd1, 8'h01, 8'h80, 8'h7f));
		send_point(make_point(32'sd1, -32'sd1, 32'sd1, 8'hfe, 8'h7f, 8'h80));
		send_point(make_point(32'sh0001_0000, -32'sh0002_8000, 32'sh0000_8000,
			8'h12, 8'h34, 8'h56));
		settle_idle();
	endtask

	// extreme register values, heading outside the unit circle
	task automatic test_extreme_config();
		load_config(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
			Q_MAX, Q_MAX, Q_MAX, 16'h7fff, 16'h7fff);
		send_point(make_point(Q_MAX, Q_MAX, Q_MAX, 8'hff, 8'h00, 8'hff));
		send_point(make_point(Q_MIN, Q_MIN, Q_MIN, 8'h00, 8'hff, 8'h00));
		send_point(make_point(32'sd0, 32'sd0, 32'sd0, 8'h80, 8'h80, 8'h80));
		send_point(make_point(-32'sh0001_0000, 32'sh0000_0010, 32'sd1, 8'h01, 8'h02, 8'h03));
		settle_idle();
		load_config(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
			Q_MIN, Q_MIN, Q_MIN, 16'h8000, 16'h8000);
		send_point(make_point(Q_MAX, Q_MAX, Q_MAX, 8'hff, 8'hff, 8'hff));
		send_point(make_point(Q_MIN, Q_MIN, Q_MIN, 8'h00, 8'h00, 8'h00));
		send_point(make_point(32'sd0, 32'sd0, 32'sd0, 8'h0f, 8'hf0, 8'h0f));
		send_point(make_point(32'sd1, -32'sd1, 32'sd0, 8'hf0, 8'h0f, 8'hf0));
		settle_idle();
		load_config(48'h0, 48'h0, 48'h0, 32'h0, 32'h0, 32'h0, 16'hc000, 16'h4000);
		send_point(make_point(Q_MAX, Q_MIN, Q_MAX, 8'h33, 8'hcc, 8'h33));
		send_point(make_point(32'sd0, 32'sd0, 32'sd0, 8'hcc, 8'h33, 8'hcc));
		settle_idle();
		load_config(48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000,
			32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 16'h4000, 16'hc000);
		send_point(make_point(32'sh0003_0000, -32'sh0001_0000, 32'sh0002_0000,
			8'h11, 8'h22, 8'h33));
		send_point(make_point(-32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
			8'h44, 8'h55, 8'h66));
		settle_idle();
	endtask

	// several random settings, near-rigid and arbitrary in turn
	task automatic test_random_config();
		bit wild;
		for (int n = 0; n < 5; n++) begin
			wild = (n % 2 == 1);
			load_config(random_line(0, wild), random_line(1, wild), random_line(2, wild),
				wild ? $urandom : 32'(int'($urandom_range(0, 8388608)) - 4194304),
				wild ? $urandom : 32'(int'($urandom_range(0, 8388608)) - 4194304),
				wild ? $urandom : 32'(int'($urandom_range(0, 8388608)) - 4194304),
				wild ? 16'($urandom) : 16'(int'($urandom_range(0, 32768)) - 16384),
				wild ? 16'($urandom) : 16'(int'($urandom_range(0, 32768)) - 16384));
			send_random_points(80);
			settle_idle();
		end
	endtask

	// back to back words, no stalls on either side
	task automatic test_full_rate();
		idle_on <= 1'b0;
		load_config(random_line(0, 1'b0), random_line(1, 1'b0), random_line(2, 1'b0),
			32'(int'($urandom_range(0, 8388608)) - 4194304), 32'h0, 32'h0,
			16'h3b21, 16'h187e);
		send_random_points(60);
		settle_idle();
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				m_tready <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 14);
			m_tready   <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		result_t     want;
		logic [31:0] want_f, got_f, mask;
		int          k;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_results.size() == 0) begin
				n_err++;
				if (n_err <= MAX_REPORTS)
					$display("%0t: result word with nothing expected: %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				for (k = 0; k < NUM_FIELDS; k++) begin
					mask   = (k >= 3 && k < 6) ? 32'h0000_00ff : 32'hffff_ffff;
					want_f = want[field_lsb(k) +: 32] & mask;
					got_f  = m_tdata[field_lsb(k) +: 32] & mask;
					if (got_f !== want_f) begin
						n_err++;
						if (n_err <= MAX_REPORTS)
							$display("%0t: %s expected %h got %h", $time, field_name(k),
								want_f, got_f);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_extreme_config();
		test_random_config();
		test_full_rate();
		if (n_err == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
